/* sv/slotted_page_record_store_unit_macros.svh */
// assertion macros for the slotted page record store checker
// used by spsu_checker, needs clk_i and rst_ni in scope
`ifndef SLOTTED_PAGE_RECORD_STORE_UNIT_MACROS_SVH
`define SLOTTED_PAGE_RECORD_STORE_UNIT_MACROS_SVH

`define SPSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define SPSU_NEVER(lbl, cond, msg) \
  `SPSU_ASSERT(lbl, !(cond), msg)

`endif

/* sv/spsu_pkg.sv */
// shared types and constants of the slotted page record store
// no dependencies
package spsu_pkg;

  localparam int PageBytes  = 4096;
  localparam int EntryBytes = 4;
  localparam int MaxSlots   = 1024;
  localparam int AddrW      = $clog2(PageBytes);
  localparam int SlotW      = $clog2(MaxSlots);
  localparam int OffW       = AddrW + 1;
  localparam int CountW     = SlotW + 1;
  localparam int NeedW      = OffW + 2;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_WRITE   = 3'd1,
    OP_READ    = 3'd2,
    OP_DELETE  = 3'd3,
    OP_COMPACT = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_SPACE = 3'd1,
    ST_BAD_SLOT = 3'd2,
    ST_DELETED  = 3'd3,
    ST_RANGE    = 3'd4
  } status_e;

  typedef struct packed {
    logic [OffW-1:0] start;
    logic [OffW-1:0] size;
    logic            live;
  } entry_t;

  typedef struct packed {
    op_e              op;
    logic [SlotW-1:0] slot;
    logic [AddrW-1:0] idx;
    logic [7:0]       din;
    logic [OffW-1:0]  len;
  } req_t;

  typedef struct packed {
    status_e           status;
    logic [SlotW-1:0]  slot;
    logic [7:0]        data;
    logic [OffW-1:0]   length;
    logic [CountW-1:0] count;
    logic [OffW-1:0]   free;
  } res_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [SlotW-1:0] waddr;
    logic [SlotW-1:0] raddr;
    entry_t           wdata;
  } slot_req_t;

  typedef struct packed {
    logic             we;
    logic             re;
    logic [AddrW-1:0] addr;
    logic [7:0]       wdata;
  } page_req_t;

endpackage

/* sv/spsu_page_ram.sv */
// byte page memory, one port, registered read
// depends on spsu_pkg
module spsu_page_ram (
  input  logic               clk_i,
  input  spsu_pkg::page_req_t req_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem [spsu_pkg::PageBytes];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.addr];
    end
  end

endmodule

/* sv/spsu_slot_ram.sv */
// slot table memory, one write and one read port, registered read
// depends on spsu_pkg
module spsu_slot_ram (
  input  logic                clk_i,
  input  spsu_pkg::slot_req_t req_i,
  output spsu_pkg::entry_t    rdata_o
);

  spsu_pkg::entry_t mem [spsu_pkg::MaxSlots];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_o <= mem[req_i.raddr];
    end
  end

endmodule

/* sv/spsu_ctrl.sv */
// sequencer of the record store: operation decode, space check, compaction walk
// depends on spsu_pkg, drives spsu_slot_ram and spsu_page_ram
module spsu_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spsu_pkg::req_t      in_i,
  input  logic                out_free_i,
  output logic                res_valid_o,
  output spsu_pkg::res_t      res_o,
  output spsu_pkg::slot_req_t slot_req_o,
  input  spsu_pkg::entry_t    slot_rdata_i,
  output spsu_pkg::page_req_t page_req_o,
  input  logic [7:0]          page_rdata_i
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_EXEC   = 7'b0000010,
    S_RDWAIT = 7'b0000100,
    S_CSLOT  = 7'b0001000,
    S_CENT   = 7'b0010000,
    S_CBRD   = 7'b0100000,
    S_CBWR   = 7'b1000000
  } state_e;

  localparam int OffW   = spsu_pkg::OffW;
  localparam int CountW = spsu_pkg::CountW;
  localparam int SlotW  = spsu_pkg::SlotW;
  localparam int AddrW  = spsu_pkg::AddrW;
  localparam int NeedW  = spsu_pkg::NeedW;

  state_e              state_q, state_d;
  spsu_pkg::req_t      req_q, req_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [OffW-1:0]     free_q, free_d;
  logic [CountW-1:0]   ci_q, ci_d;
  logic [CountW-1:0]   kept_q, kept_d;
  logic [OffW-1:0]     top_q, top_d;
  logic [OffW-1:0]     src_q, src_d;
  logic [OffW-1:0]     k_q, k_d;
  logic [OffW-1:0]     csize_q, csize_d;

  logic signed [NeedW-1:0] room, need;
  logic [OffW-1:0]         off, addr;
  logic [OffW-1:0]         rd_addr, wr_addr;
  logic                    bad_slot;

  always_comb begin
    room     = $signed({2'b00, free_q}) - $signed({2'b00, req_q.len});
    need     = $signed({{(NeedW-CountW){1'b0}}, count_q} + {{(NeedW-1){1'b0}}, 1'b1})
               * $signed(NeedW'(spsu_pkg::EntryBytes));
    off      = {1'b0, req_q.idx};
    addr     = slot_rdata_i.start + off;
    bad_slot = {1'b0, req_q.slot} >= count_q;
    rd_addr  = src_q + k_q - OffW'(1);
    wr_addr  = top_q + k_q;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    count_d     = count_q;
    free_d      = free_q;
    ci_d        = ci_q;
    kept_d      = kept_q;
    top_d       = top_q;
    src_d       = src_q;
    k_d         = k_q;
    csize_d     = csize_q;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.status = spsu_pkg::ST_OK;
    slot_req_o  = '0;
    page_req_o  = '0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d            = in_i;
          slot_req_o.re    = 1'b1;
          slot_req_o.raddr = in_i.slot;
          state_d          = S_EXEC;
        end
      end
      S_EXEC: begin
        case (req_q.op)
          spsu_pkg::OP_INSERT: begin
            if (out_free_i) begin
              res_valid_o  = 1'b1;
              res_o.length = req_q.len;
              if (count_q >= CountW'(spsu_pkg::MaxSlots) || room < need) begin
                res_o.status = spsu_pkg::ST_NO_SPACE;
              end else begin
                slot_req_o.we          = 1'b1;
                slot_req_o.waddr       = count_q[SlotW-1:0];
                slot_req_o.wdata.start = free_q - req_q.len;
                slot_req_o.wdata.size  = req_q.len;
                slot_req_o.wdata.live  = 1'b1;
                res_o.slot             = count_q[SlotW-1:0];
                count_d                = count_q + CountW'(1);
                free_d                 = free_q - req_q.len;
              end
              state_d = S_IDLE;
            end
          end
          spsu_pkg::OP_WRITE, spsu_pkg::OP_READ, spsu_pkg::OP_DELETE: begin
            if (bad_slot) begin
              if (out_free_i) begin
                res_valid_o  = 1'b1;
                res_o.status = spsu_pkg::ST_BAD_SLOT;
                state_d      = S_IDLE;
              end
            end else if (req_q.op == spsu_pkg::OP_DELETE) begin
              if (out_free_i) begin
                res_valid_o           = 1'b1;
                res_o.length          = slot_rdata_i.size;
                slot_req_o.we         = 1'b1;
                slot_req_o.waddr      = req_q.slot;
                slot_req_o.wdata      = slot_rdata_i;
                slot_req_o.wdata.live = 1'b0;
                state_d               = S_IDLE;
              end
            end else if (!slot_rdata_i.live || off >= slot_rdata_i.size) begin
              if (out_free_i) begin
                res_valid_o  = 1'b1;
                res_o.length = slot_rdata_i.size;
                res_o.status = !slot_rdata_i.live ? spsu_pkg::ST_DELETED
                                                  : spsu_pkg::ST_RANGE;
                state_d      = S_IDLE;
              end
            end else if (req_q.op == spsu_pkg::OP_READ && !addr[AddrW]) begin
              page_req_o.re   = 1'b1;
              page_req_o.addr = addr[AddrW-1:0];
              state_d         = S_RDWAIT;
            end else if (out_free_i) begin
              res_valid_o      = 1'b1;
              res_o.length     = slot_rdata_i.size;
              page_req_o.we    = (req_q.op == spsu_pkg::OP_WRITE) && !addr[AddrW];
              page_req_o.addr  = addr[AddrW-1:0];
              page_req_o.wdata = req_q.din;
              state_d          = S_IDLE;
            end
          end
          spsu_pkg::OP_COMPACT: begin
            ci_d    = '0;
            kept_d  = '0;
            top_d   = OffW'(spsu_pkg::PageBytes);
            state_d = S_CSLOT;
          end
          default: begin
            if (out_free_i) begin
              res_valid_o = 1'b1;
              state_d     = S_IDLE;
            end
          end
        endcase
      end
      S_RDWAIT: begin
        if (out_free_i) begin
          res_valid_o  = 1'b1;
          res_o.length = slot_rdata_i.size;
          res_o.data   = page_rdata_i;
          state_d      = S_IDLE;
        end
      end
      S_CSLOT: begin
        if (ci_q >= count_q) begin
          if (out_free_i) begin
            res_valid_o = 1'b1;
            count_d     = kept_q;
            free_d      = top_q;
            state_d     = S_IDLE;
          end
        end else begin
          slot_req_o.re    = 1'b1;
          slot_req_o.raddr = ci_q[SlotW-1:0];
          state_d          = S_CENT;
        end
      end
      S_CENT: begin
        if (!slot_rdata_i.live) begin
          ci_d    = ci_q + CountW'(1);
          state_d = S_CSLOT;
        end else begin
          csize_d = (slot_rdata_i.size > top_q) ? top_q : slot_rdata_i.size;
          src_d   = slot_rdata_i.start;
          top_d   = top_q - csize_d;
          k_d     = csize_d;
          state_d = S_CBRD;
        end
      end
      S_CBRD: begin
        if (k_q == '0) begin
          slot_req_o.we          = 1'b1;
          slot_req_o.waddr       = kept_q[SlotW-1:0];
          slot_req_o.wdata.start = top_q;
          slot_req_o.wdata.size  = csize_q;
          slot_req_o.wdata.live  = 1'b1;
          kept_d                 = kept_q + CountW'(1);
          ci_d                   = ci_q + CountW'(1);
          state_d                = S_CSLOT;
        end else begin
          page_req_o.re   = 1'b1;
          page_req_o.addr = rd_addr[AddrW-1:0];
          k_d             = k_q - OffW'(1);
          state_d         = S_CBWR;
        end
      end
      S_CBWR: begin
        page_req_o.we    = 1'b1;
        page_req_o.addr  = wr_addr[AddrW-1:0];
        page_req_o.wdata = page_rdata_i;
        state_d          = S_CBRD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_o.count = count_d;
    res_o.free  = free_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      free_q  <= OffW'(spsu_pkg::PageBytes);
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      free_q  <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    ci_q    <= ci_d;
    kept_q  <= kept_d;
    top_q   <= top_d;
    src_q   <= src_d;
    k_q     <= k_d;
    csize_q <= csize_d;
  end

endmodule

/* sv/slotted_page_record_store_unit.sv */
// top level of the slotted page record store: stream ports and result register
// depends on spsu_pkg, spsu_ctrl, spsu_slot_ram, spsu_page_ram
//
// one request channel (s_axis) and one result channel (m_axis); every request
// transaction yields exactly one result transaction, in order.
// s_axis_tuser carries the operation, s_axis_tdata the slot, byte index,
// data byte and record length; m_axis_tuser carries the status, m_axis_tdata
// the assigned slot, read byte, record length, slot count and free offset.
// one request is worked on at a time; the slot table and the page are
// single synchronous memories with registered read.
// a read does a slot table read, then a page read; compact walks the slot
// table and moves each live record byte by byte to the top of the page.
// a new request is taken in the cycle after its result enters the output
// register.
// after reset the table is empty and the free offset is the page size;
// page and table contents are not cleared.
// when the receiver stalls, the result waits in the output register and the
// next request may still be taken; its result waits until the register frees.
module slotted_page_record_store_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // slot, byte_index, data_in, record_length
  input  logic [2:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // slot_out, data_out, length_out, count_out, free_out
  output logic [2:0]  m_axis_tuser    // status
);

  spsu_pkg::req_t      req;
  spsu_pkg::res_t      res, out_q;
  spsu_pkg::slot_req_t slot_req;
  spsu_pkg::page_req_t page_req;
  spsu_pkg::entry_t    slot_rdata;
  logic [7:0]          page_rdata;
  logic                res_valid, out_valid_q, out_free;

  always_comb begin
    req.op   = spsu_pkg::op_e'(s_axis_tuser);
    req.slot = s_axis_tdata[9:0];
    req.idx  = s_axis_tdata[21:10];
    req.din  = s_axis_tdata[29:22];
    req.len  = s_axis_tdata[42:30];
    out_free = !out_valid_q || m_axis_tready;
  end

  spsu_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_i         (req),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .slot_req_o   (slot_req),
    .slot_rdata_i (slot_rdata),
    .page_req_o   (page_req),
    .page_rdata_i (page_rdata)
  );

  spsu_slot_ram u_slot_ram (
    .clk_i   (clk_i),
    .req_i   (slot_req),
    .rdata_o (slot_rdata)
  );

  spsu_page_ram u_page_ram (
    .clk_i   (clk_i),
    .req_i   (page_req),
    .rdata_o (page_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {1'b0, out_q.free, out_q.count, out_q.length, out_q.data,
                          out_q.slot};

endmodule

/* sv/spsu_checker.sv */
// port level checks of the slotted page record store, bound to the top level
// depends on slotted_page_record_store_unit_macros.svh
`include "slotted_page_record_store_unit_macros.svh"

module spsu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [47:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  logic [12:0] free_o;
  logic [10:0] count_o;
  logic [9:0]  slot_o;

  assign free_o  = m_axis_tdata[54:42];
  assign count_o = m_axis_tdata[41:31];
  assign slot_o  = m_axis_tdata[9:0];

  `SPSU_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
  `SPSU_NEVER(a_status, m_axis_tvalid && m_axis_tuser > 3'd4, "bad status code")
  `SPSU_NEVER(a_room, m_axis_tvalid && free_o < {count_o, 2'b00}, "table overlaps records")
  `SPSU_NEVER(a_noslot, m_axis_tvalid && m_axis_tuser != 3'd0 && slot_o != 10'd0, "slot on failure")

endmodule

bind slotted_page_record_store_unit spsu_checker u_spsu_checker (.*);
